[src/tiac_pkg.sv]
// ----------------------------------------------------------------------------
// tiac_pkg
// Shared sizes and types for the endpoint id / address converter pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package tiac_pkg;

    // Network dimension limit and the number of coordinate fields on the ports
    localparam int MAX_DIMS   = 4;
    localparam int FIELD_DIMS = 4;
    localparam int ACT_DIMS   = (MAX_DIMS < FIELD_DIMS) ? MAX_DIMS : FIELD_DIMS;

    // One divide unit for the local digit plus one per dimension
    localparam int NUM_UNITS       = ACT_DIMS + 1;
    localparam int ID_W            = 32;
    localparam int DIGIT_W         = 16;
    localparam int STEPS_PER_STAGE = 4;
    localparam int STAGES_PER_UNIT = ID_W / STEPS_PER_STAGE;
    localparam int NUM_STAGES      = NUM_UNITS * STAGES_PER_UNIT;

    localparam int UNIT_W = (NUM_UNITS > 1) ? $clog2(NUM_UNITS) : 1;
    localparam int SUB_W  = (STAGES_PER_UNIT > 1) ? $clog2(STAGES_PER_UNIT) : 1;
    localparam int DIMI_W = (ACT_DIMS > 1) ? $clog2(ACT_DIMS) : 1;
    localparam int DIM_W  = $clog2(ACT_DIMS + 1);

    // Register indexes
    localparam logic [2:0] REG_CONC   = 3'd0;
    localparam logic [2:0] REG_DIMS   = 3'd1;
    localparam logic [2:0] REG_RADIX0 = 3'd2;

    // Commands
    localparam logic CMD_SPLIT   = 1'b0;
    localparam logic CMD_COMBINE = 1'b1;

    // Configuration as seen by the pipeline
    typedef struct packed {
        logic [DIGIT_W-1:0]                 conc;
        logic [DIM_W-1:0]                   n;
        logic [ACT_DIMS-1:0][DIGIT_W-1:0]   radix;
    } t_cfg;

    // One word in flight
    typedef struct packed {
        logic                               valid;
        logic                               cmd;
        logic [ID_W-1:0]                    quo;
        logic [DIGIT_W-1:0]                 rem;
        logic [NUM_UNITS-1:0][DIGIT_W-1:0]  digit;
        logic [ID_W-1:0]                    sum;
        logic [ID_W-1:0]                    prod;
        logic                               err;
    } t_stage;

endpackage

`default_nettype wire

[src/tiac_stage.sv]
// ----------------------------------------------------------------------------
// tiac_stage
// One pipeline stage: a few restoring-division steps, plus one
// multiply-accumulate step of the combine path entering each active unit.
// ----------------------------------------------------------------------------
`default_nettype none

module tiac_stage
    import tiac_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_en,
    input  wire logic [UNIT_W-1:0]  i_unit,
    input  wire logic [SUB_W-1:0]   i_sub,
    input  wire t_cfg               i_cfg,
    input  wire t_stage             i_d,
    output t_stage                  o_q
);

    t_stage r_q;
    t_stage n_q;

    always_comb begin
        logic [DIGIT_W-1:0]  den;
        logic [DIGIT_W:0]    r17;
        logic                ge;
        logic [UNIT_W-1:0]   dm;
        logic [DIGIT_W-1:0]  dig;
        logic [DIGIT_W-1:0]  rad;
        logic [47:0]         m_sum;
        logic [47:0]         m_prod;
        n_q   = i_d;
        dm    = i_unit - 1'b1;
        dig   = i_d.digit[i_unit];
        rad   = i_cfg.radix[dm[DIMI_W-1:0]];
        den   = (i_unit == '0) ? i_cfg.conc : rad;
        m_sum  = i_d.prod * dig;
        m_prod = i_d.prod * rad;

        // unit entry: restart remainder, step the combine path
        if (i_sub == '0) begin
            n_q.rem = '0;
            if (i_unit == '0) begin
                n_q.sum  = {{(ID_W-DIGIT_W){1'b0}}, dig};
                n_q.prod = {{(ID_W-DIGIT_W){1'b0}}, i_cfg.conc};
                n_q.err  = (dig >= i_cfg.conc);
            end else if ({1'b0, dm} < {1'b0, i_cfg.n}) begin
                n_q.sum  = i_d.sum + m_sum[ID_W-1:0];
                n_q.prod = m_prod[ID_W-1:0];
                n_q.err  = i_d.err | (dig >= rad);
            end
        end

        // restoring division, one quotient bit per step
        for (int k = 0; k < STEPS_PER_STAGE; k++) begin
            r17     = {n_q.rem, n_q.quo[ID_W-1]};
            ge      = (r17 >= {1'b0, den});
            n_q.quo = {n_q.quo[ID_W-2:0], ge};
            n_q.rem = ge ? DIGIT_W'(r17 - {1'b0, den}) : r17[DIGIT_W-1:0];
        end

        // unit exit: remainder is this unit's digit
        if (i_sub == SUB_W'(STAGES_PER_UNIT - 1)) begin
            n_q.digit[i_unit] = n_q.rem;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q.valid <= 1'b0;
        end else if (i_en) begin
            r_q <= n_q;
        end
    end

    assign o_q = r_q;

endmodule

`default_nettype wire

[src/torus_endpoint_id_address_convert.sv]
// ----------------------------------------------------------------------------
// torus_endpoint_id_address_convert
// Flat endpoint number <-> mixed-radix cube-network address converter.
// ----------------------------------------------------------------------------
// Takes one word per cycle when the output is not held, and returns one
// result word per input word, in order, from the output register behind
// a chain of pipelined dividers: one divide unit for the local digit and
// one per dimension, each eight stages of four restoring-division steps.
// The whole pipeline stalls together while the output word is held. The
// user must write configuration only while idle; this is not enforced.
`default_nettype none

module torus_endpoint_id_address_convert
    import tiac_pkg::*;
(
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    // configuration write channel
    input  wire logic           i_cfg_valid,
    output logic                o_cfg_ready,
    input  wire logic [2:0]     i_cfg_index,
    input  wire logic [15:0]    i_cfg_data,
    // input stream
    input  wire logic           i_s_tvalid,
    output logic                o_s_tready,
    // flat_id[31:0], local_index[47:32], coord_0..coord_3[111:48]
    input  wire logic [111:0]   i_s_tdata,
    // cmd[0]
    input  wire logic [0:0]     i_s_tuser,
    // output stream
    output logic                o_m_tvalid,
    input  wire logic           i_m_tready,
    // flat_id_out[31:0], local_out[47:32], coord_out_0..coord_out_3[111:48]
    output logic [111:0]        o_m_tdata,
    // digit_error[0]
    output logic [0:0]          o_m_tuser
);

    // configuration registers
    logic [DIGIT_W-1:0]                   r_conc;
    logic [2:0]                           r_dims;
    logic [FIELD_DIMS-1:0][DIGIT_W-1:0]   r_radix;
    t_cfg                                 w_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_conc  <= 16'd1;
            r_dims  <= 3'd1;
            r_radix <= {FIELD_DIMS{16'd2}};
        end else if (i_cfg_valid) begin
            if (i_cfg_index == REG_CONC) begin
                r_conc <= i_cfg_data;
            end else if (i_cfg_index == REG_DIMS) begin
                r_dims <= i_cfg_data[2:0];
            end else begin
                for (int i = 0; i < FIELD_DIMS; i++) begin
                    if (i_cfg_index == REG_RADIX0 + 3'(i)) begin
                        r_radix[i] <= i_cfg_data;
                    end
                end
            end
        end
    end

    assign o_cfg_ready = 1'b1;

    // active dimension count, capped
    always_comb begin
        w_cfg.conc = r_conc;
        if ({1'b0, r_dims} > 4'(ACT_DIMS)) begin
            w_cfg.n = DIM_W'(ACT_DIMS);
        end else begin
            w_cfg.n = DIM_W'(r_dims);
        end
        for (int i = 0; i < ACT_DIMS; i++) begin
            w_cfg.radix[i] = r_radix[i];
        end
    end

    // global advance
    logic r_out_valid;
    logic w_en;
    assign w_en       = !r_out_valid || i_m_tready;
    assign o_s_tready = w_en;

    // entry word
    t_stage w_entry;
    t_stage w_chain [0:NUM_STAGES];

    always_comb begin
        w_entry          = '0;
        w_entry.valid    = i_s_tvalid;
        w_entry.cmd      = i_s_tuser[0];
        w_entry.quo      = i_s_tdata[31:0];
        w_entry.digit[0] = i_s_tdata[47:32];
        for (int i = 0; i < ACT_DIMS; i++) begin
            w_entry.digit[i+1] = i_s_tdata[48 + 16*i +: 16];
        end
    end

    assign w_chain[0] = w_entry;

    // divide / accumulate pipeline
    for (genvar g = 0; g < NUM_STAGES; g++) begin : g_stage
        tiac_stage u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_unit  (UNIT_W'(g / STAGES_PER_UNIT)),
            .i_sub   (SUB_W'(g % STAGES_PER_UNIT)),
            .i_cfg   (w_cfg),
            .i_d     (w_chain[g]),
            .o_q     (w_chain[g+1])
        );
    end

    // result formatting
    t_stage         w_last;
    logic [111:0]   n_data;
    logic           n_err;
    logic [111:0]   r_out_data;
    logic           r_out_err;

    assign w_last = w_chain[NUM_STAGES];

    always_comb begin
        n_data = '0;
        n_err  = 1'b0;
        if (w_last.cmd == CMD_COMBINE) begin
            n_data[31:0] = w_last.sum;
            n_err        = w_last.err;
        end else begin
            n_data[47:32] = w_last.digit[0];
            for (int i = 0; i < ACT_DIMS; i++) begin
                if (DIM_W'(i) < w_cfg.n) begin
                    n_data[48 + 16*i +: 16] = w_last.digit[i+1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= w_last.valid;
            r_out_data  <= n_data;
            r_out_err   <= n_err;
        end
    end

    assign o_m_tvalid   = r_out_valid;
    assign o_m_tdata    = r_out_data;
    assign o_m_tuser[0] = r_out_err;

    // checks
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |-> !o_s_tready)
        else $error("input taken while output stalled");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> $stable(w_last) && o_m_tvalid)
        else $error("pipeline moved during stall");

    a_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser[0] |-> o_m_tdata[111:32] == '0)
        else $error("digit error on a split result");

endmodule

`default_nettype wire
